[design/axis_angle_rotation_matrix_unit_defines.svh]
// Assertion macros shared by the rotation matrix unit modules.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_UNIT_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define AARM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define AARM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/aarm_pkg.sv]
// Shared constants, types and the arctangent table of the rotation matrix unit.
package aarm_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;
  localparam int CORDIC_CELLS  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int IDX_W         = $clog2(ATAN_ENTRIES);

  localparam int AXIS_W = 16;
  localparam int ANG_W  = 16;
  localparam int RES_W  = 16;
  localparam int CW     = 32;  // CORDIC word, units of 2^-29
  localparam int WRAP_W = 34;  // widened angle before wrap and fold

  localparam logic signed [WRAP_W-1:0] ANG_PI_W      = 34'sd1686629713;
  localparam logic signed [WRAP_W-1:0] ANG_TWO_PI_W  = 34'sd3373259426;
  localparam logic signed [WRAP_W-1:0] ANG_HALF_PI_W = 34'sd843314857;
  localparam logic signed [CW-1:0]     ANG_HALF_PI   = 32'sd843314857;
  localparam logic signed [CW-1:0]     CORDIC_GAIN   = 32'sd326016437;

  typedef struct packed {
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
    logic                     cneg;
    logic signed [CW-1:0]     x;
    logic signed [CW-1:0]     y;
    logic signed [CW-1:0]     z;
  } cell_data_t;

  // round(atan(2^-i) * 2^29)
  function automatic logic signed [CW-1:0] atan_lut(input logic [IDX_W-1:0] idx);
    logic signed [CW-1:0] v;
    case (idx)
      5'd0:    v = 32'sd421657428;
      5'd1:    v = 32'sd248918915;
      5'd2:    v = 32'sd131521918;
      5'd3:    v = 32'sd66762579;
      5'd4:    v = 32'sd33510843;
      5'd5:    v = 32'sd16771758;
      5'd6:    v = 32'sd8387925;
      5'd7:    v = 32'sd4194219;
      5'd8:    v = 32'sd2097141;
      5'd9:    v = 32'sd1048575;
      5'd10:   v = 32'sd524288;
      5'd11:   v = 32'sd262144;
      5'd12:   v = 32'sd131072;
      5'd13:   v = 32'sd65536;
      5'd14:   v = 32'sd32768;
      5'd15:   v = 32'sd16384;
      5'd16:   v = 32'sd8192;
      5'd17:   v = 32'sd4096;
      5'd18:   v = 32'sd2048;
      5'd19:   v = 32'sd1024;
      5'd20:   v = 32'sd512;
      5'd21:   v = 32'sd256;
      5'd22:   v = 32'sd128;
      5'd23:   v = 32'sd64;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/aarm_prep.sv]
// Input stages: widen the angle, wrap it into +-pi and fold it into +-pi/2.
module aarm_prep (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [aarm_pkg::AXIS_W-1:0]  in_axis_x,
  input  logic signed [aarm_pkg::AXIS_W-1:0]  in_axis_y,
  input  logic signed [aarm_pkg::AXIS_W-1:0]  in_axis_z,
  input  logic signed [aarm_pkg::ANG_W-1:0]   in_angle,
  output logic                                dn_valid,
  input  logic                                dn_ready,
  output aarm_pkg::cell_data_t                dn_data
);

  logic                                  va_r, vb_r;
  logic                                  rdy_a, rdy_b;
  logic signed [aarm_pkg::AXIS_W-1:0]    ax_r, ay_r, az_r;
  logic signed [aarm_pkg::WRAP_W-1:0]    ang_r, ang_nxt, ang_ext;
  logic signed [aarm_pkg::WRAP_W-1:0]    fold_w;
  aarm_pkg::cell_data_t                  dat_r, dat_nxt;

  assign rdy_b    = !vb_r || dn_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;
  assign dn_valid = vb_r;
  assign dn_data  = dat_r;

  always_comb begin
    ang_ext = $signed({{(aarm_pkg::WRAP_W - aarm_pkg::ANG_W - 16){in_angle[aarm_pkg::ANG_W-1]}},
                       in_angle, 16'b0});
    if (ang_ext > aarm_pkg::ANG_PI_W) begin
      ang_nxt = ang_ext - aarm_pkg::ANG_TWO_PI_W;
    end else if (ang_ext < -aarm_pkg::ANG_PI_W) begin
      ang_nxt = ang_ext + aarm_pkg::ANG_TWO_PI_W;
    end else begin
      ang_nxt = ang_ext;
    end
  end

  // fold past +-pi/2: sine keeps, cosine flips
  always_comb begin
    dat_nxt.ax   = ax_r;
    dat_nxt.ay   = ay_r;
    dat_nxt.az   = az_r;
    dat_nxt.x    = aarm_pkg::CORDIC_GAIN;
    dat_nxt.y    = '0;
    dat_nxt.cneg = 1'b0;
    fold_w       = ang_r;
    if (ang_r > aarm_pkg::ANG_HALF_PI_W) begin
      fold_w       = aarm_pkg::ANG_PI_W - ang_r;
      dat_nxt.cneg = 1'b1;
    end else if (ang_r < -aarm_pkg::ANG_HALF_PI_W) begin
      fold_w       = -aarm_pkg::ANG_PI_W - ang_r;
      dat_nxt.cneg = 1'b1;
    end
    dat_nxt.z = $signed(fold_w[aarm_pkg::CW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
    end
    if (rdy_a) begin
      ax_r  <= in_axis_x;
      ay_r  <= in_axis_y;
      az_r  <= in_axis_z;
      ang_r <= ang_nxt;
    end
    if (rdy_b) dat_r <= dat_nxt;
  end

endmodule

[design/aarm_cordic_cell.sv]
// One rotation-mode CORDIC iteration, registered, with its own hand-off.
`include "axis_angle_rotation_matrix_unit_defines.svh"

module aarm_cordic_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [aarm_pkg::IDX_W-1:0]     stage_idx,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  aarm_pkg::cell_data_t           up_data,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output aarm_pkg::cell_data_t           dn_data
);

  logic                          valid_r;
  aarm_pkg::cell_data_t          data_r, data_nxt;
  logic signed [aarm_pkg::CW-1:0] dx, dy, at;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    dx       = up_data.y >>> stage_idx;
    dy       = up_data.x >>> stage_idx;
    at       = aarm_pkg::atan_lut(stage_idx);
    data_nxt = up_data;
    if (!up_data.z[aarm_pkg::CW-1]) begin
      data_nxt.x = up_data.x - dx;
      data_nxt.y = up_data.y + dy;
      data_nxt.z = up_data.z - at;
    end else begin
      data_nxt.x = up_data.x + dx;
      data_nxt.y = up_data.y - dy;
      data_nxt.z = up_data.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
    if (up_ready) data_r <= data_nxt;
  end

  `AARM_ASSERT_NXT(a_cell_hold, valid_r && !dn_ready, valid_r, "cell dropped a stalled beat")
  `AARM_ASSERT_IMP(a_cell_zrange, valid_r,
    (data_r.z <= aarm_pkg::ANG_HALF_PI) && (data_r.z >= -aarm_pkg::ANG_HALF_PI),
    "residual angle left the folded range")

endmodule

[design/aarm_post.sv]
// Back end: round cosine and sine, form products, sum, round and saturate.
`include "axis_angle_rotation_matrix_unit_defines.svh"

module aarm_post (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                up_valid,
  output logic                                up_ready,
  input  aarm_pkg::cell_data_t                up_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [8:0][aarm_pkg::RES_W-1:0]     res
);

  localparam int AW    = aarm_pkg::AXIS_W;
  localparam int C_W   = 26;
  localparam int OMC_W = C_W + 1;
  localparam int PP_W  = 2 * AW;
  localparam int PS_W  = AW + C_W;
  localparam int PM_W  = PP_W + OMC_W;
  localparam int ACC_W = 62;
  localparam int NST   = 5;

  localparam logic signed [OMC_W-1:0] ONE_C    = 27'sd16777216;
  localparam logic signed [ACC_W-1:0] ROUND    = $signed({{(ACC_W-38){1'b0}}, 1'b1, 37'b0});
  localparam logic signed [ACC_W-1:0] ONE_Q14  = ACC_W'(16384);

  function automatic logic [aarm_pkg::RES_W-1:0] sat_q14(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] q;
    q = a >>> 38;
    if (q > ONE_Q14) begin
      q = ONE_Q14;
    end else if (q < -ONE_Q14) begin
      q = -ONE_Q14;
    end
    return q[aarm_pkg::RES_W-1:0];
  endfunction

  logic [NST-1:0] v_r;
  logic [NST:0]   rdy;

  // stage 1: cosine and sine at 2^-24
  logic signed [AW-1:0]   ax1_r, ay1_r, az1_r;
  logic signed [C_W-1:0]  c1_r, s1_r, c1_nxt, s1_nxt;
  logic signed [aarm_pkg::CW-1:0] xs;
  logic signed [aarm_pkg::CW:0]   xr, yr;
  // stage 2: first products
  logic signed [OMC_W-1:0] omc2_r;
  logic signed [C_W-1:0]   c2_r;
  logic signed [PP_W-1:0]  pxx2_r, pyy2_r, pzz2_r, pxy2_r, pxz2_r, pyz2_r;
  logic signed [PS_W-1:0]  sx2_r, sy2_r, sz2_r;
  // stage 3: times (1 - c)
  logic signed [C_W-1:0]   c3_r;
  logic signed [PM_W-1:0]  mxx3_r, myy3_r, mzz3_r, mxy3_r, mxz3_r, myz3_r;
  logic signed [PS_W-1:0]  sx3_r, sy3_r, sz3_r;
  // stage 4: sums with rounding offset; stage 5: result
  logic signed [ACC_W-1:0] acc4_r [9];
  logic signed [ACC_W-1:0] acc4_nxt [9];
  logic signed [PS_W+13:0] ct, tsx, tsy, tsz;
  logic [aarm_pkg::RES_W-1:0] res5_r [9];

  assign rdy[NST] = out_ready;
  for (genvar k = 0; k < NST; k++) begin : g_rdy
    assign rdy[k] = !v_r[k] || rdy[k+1];
  end
  assign up_ready  = rdy[0];
  assign out_valid = v_r[NST-1];
  for (genvar k = 0; k < 9; k++) begin : g_res
    assign res[k] = res5_r[k];
  end

  always_comb begin
    xs     = up_data.cneg ? -up_data.x : up_data.x;
    xr     = (aarm_pkg::CW+1)'(xs) + (aarm_pkg::CW+1)'(16);
    yr     = (aarm_pkg::CW+1)'(up_data.y) + (aarm_pkg::CW+1)'(16);
    c1_nxt = C_W'(xr >>> 5);
    s1_nxt = C_W'(yr >>> 5);
  end

  always_comb begin
    ct  = $signed({{(PS_W+14-C_W-28){c3_r[C_W-1]}}, c3_r, 28'b0});
    tsx = $signed({sx3_r, 14'b0});
    tsy = $signed({sy3_r, 14'b0});
    tsz = $signed({sz3_r, 14'b0});
    acc4_nxt[0] = mxx3_r + ct + ROUND;
    acc4_nxt[1] = mxy3_r + tsz + ROUND;
    acc4_nxt[2] = mxz3_r - tsy + ROUND;
    acc4_nxt[3] = mxy3_r - tsz + ROUND;
    acc4_nxt[4] = myy3_r + ct + ROUND;
    acc4_nxt[5] = myz3_r + tsx + ROUND;
    acc4_nxt[6] = mxz3_r + tsy + ROUND;
    acc4_nxt[7] = myz3_r - tsx + ROUND;
    acc4_nxt[8] = mzz3_r + ct + ROUND;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) v_r[0] <= up_valid;
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
    if (rdy[0]) begin
      ax1_r <= up_data.ax;
      ay1_r <= up_data.ay;
      az1_r <= up_data.az;
      c1_r  <= c1_nxt;
      s1_r  <= s1_nxt;
    end
    if (rdy[1]) begin
      omc2_r <= ONE_C - c1_r;
      c2_r   <= c1_r;
      pxx2_r <= ax1_r * ax1_r;
      pyy2_r <= ay1_r * ay1_r;
      pzz2_r <= az1_r * az1_r;
      pxy2_r <= ax1_r * ay1_r;
      pxz2_r <= ax1_r * az1_r;
      pyz2_r <= ay1_r * az1_r;
      sx2_r  <= ax1_r * s1_r;
      sy2_r  <= ay1_r * s1_r;
      sz2_r  <= az1_r * s1_r;
    end
    if (rdy[2]) begin
      c3_r   <= c2_r;
      mxx3_r <= pxx2_r * omc2_r;
      myy3_r <= pyy2_r * omc2_r;
      mzz3_r <= pzz2_r * omc2_r;
      mxy3_r <= pxy2_r * omc2_r;
      mxz3_r <= pxz2_r * omc2_r;
      myz3_r <= pyz2_r * omc2_r;
      sx3_r  <= sx2_r;
      sy3_r  <= sy2_r;
      sz3_r  <= sz2_r;
    end
    if (rdy[3]) begin
      for (int k = 0; k < 9; k++) acc4_r[k] <= acc4_nxt[k];
    end
    if (rdy[4]) begin
      for (int k = 0; k < 9; k++) res5_r[k] <= sat_q14(acc4_r[k]);
    end
  end

  `AARM_ASSERT_NXT(a_post_hold, v_r[NST-1] && !out_ready, v_r[NST-1],
    "result beat lost while stalled")
  `AARM_ASSERT_NXT(a_post_take, up_valid && rdy[0], v_r[0], "accepted beat not captured")
  `AARM_ASSERT_IMP(a_post_sat, v_r[NST-1],
    ($signed(res5_r[0]) <= 16'sd16384) && ($signed(res5_r[0]) >= -16'sd16384),
    "diagonal entry beyond saturation limit")

endmodule

[design/axis_angle_rotation_matrix_unit.sv]
// Axis-angle rotation matrix unit: input stages, CORDIC cell chain, back end.
//
// Takes a unit axis (Q2.14) and an angle in radians (Q3.13) per beat and
// returns the nine row-major entries of the 3x3 rotation block, each rounded
// to Q2.14 and saturated to +-1.0. One beat is accepted every cycle; a beat
// passes through the angle wrap and fold stages, the CORDIC cell chain, then
// five back-end stages (round cosine and sine, axis products, times one minus
// cosine, sums, round and saturate). Every stage holds its own valid bit, so a
// stall on the output only blocks input once the pipeline is full; empty slots
// collapse toward the output.
module axis_angle_rotation_matrix_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [aarm_pkg::AXIS_W-1:0]  in_axis_x,
  input  logic signed [aarm_pkg::AXIS_W-1:0]  in_axis_y,
  input  logic signed [aarm_pkg::AXIS_W-1:0]  in_axis_z,
  input  logic signed [aarm_pkg::ANG_W-1:0]   in_angle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [aarm_pkg::RES_W-1:0]   out_r00,
  output logic signed [aarm_pkg::RES_W-1:0]   out_r01,
  output logic signed [aarm_pkg::RES_W-1:0]   out_r02,
  output logic signed [aarm_pkg::RES_W-1:0]   out_r10,
  output logic signed [aarm_pkg::RES_W-1:0]   out_r11,
  output logic signed [aarm_pkg::RES_W-1:0]   out_r12,
  output logic signed [aarm_pkg::RES_W-1:0]   out_r20,
  output logic signed [aarm_pkg::RES_W-1:0]   out_r21,
  output logic signed [aarm_pkg::RES_W-1:0]   out_r22
);

  localparam int N = aarm_pkg::CORDIC_CELLS;

  aarm_pkg::cell_data_t              link_data  [N+1];
  logic                              link_valid [N+1];
  logic                              link_ready [N+1];
  logic [8:0][aarm_pkg::RES_W-1:0]   res;

  aarm_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_axis_x (in_axis_x),
    .in_axis_y (in_axis_y),
    .in_axis_z (in_axis_z),
    .in_angle  (in_angle),
    .dn_valid  (link_valid[0]),
    .dn_ready  (link_ready[0]),
    .dn_data   (link_data[0])
  );

  for (genvar k = 0; k < N; k++) begin : g_cell
    aarm_cordic_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (aarm_pkg::IDX_W'(k)),
      .up_valid  (link_valid[k]),
      .up_ready  (link_ready[k]),
      .up_data   (link_data[k]),
      .dn_valid  (link_valid[k+1]),
      .dn_ready  (link_ready[k+1]),
      .dn_data   (link_data[k+1])
    );
  end

  aarm_post u_post (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (link_valid[N]),
    .up_ready  (link_ready[N]),
    .up_data   (link_data[N]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_r00 = $signed(res[0]);
  assign out_r01 = $signed(res[1]);
  assign out_r02 = $signed(res[2]);
  assign out_r10 = $signed(res[3]);
  assign out_r11 = $signed(res[4]);
  assign out_r12 = $signed(res[5]);
  assign out_r20 = $signed(res[6]);
  assign out_r21 = $signed(res[7]);
  assign out_r22 = $signed(res[8]);

endmodule
